// ----- rtl/gnd_pkg.sv -----
// Shared constants and types for the greedy note dispenser.
package gnd_pkg;
   localparam int SLOTS = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int VAL_W = 31;
   localparam int STK_W = 16;
   localparam int DIV_CNT_W = 5;

   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_REMOVE   = 2'd1;
   localparam logic [1:0] REQ_DISPENSE = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [2:0] ST_TABLE_FULL = 3'd2;
   localparam logic [2:0] ST_SHORTFALL  = 3'd3;
   localparam logic [2:0] ST_BAD_VALUE  = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request fields
      logic do_add;     // apply add (restock or new slot)
      logic do_remove;  // free matching slot
      logic pick;       // select highest unseen slot
      logic div_start;  // start remaining / value
      logic div_step;   // one quotient bit
      logic apply;      // deduct notes, update remainder
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       found;
      logic       has_free;
      logic       best_ok;
      logic       div_done;
      logic       use_nz;
      logic       rem_nz;
   } sts_type;
endpackage

// ----- rtl/greedy_note_dispenser_top.sv -----
// Top level of the greedy note dispenser.
// One request is handled at a time. Add and remove take two steps, accept
// and update. Dispense visits each stored denomination from highest value
// down, each visit a selection step, a restoring divide of one quotient bit
// per cycle and an update step. Results leave through a register; a stalled
// result holds the sequencer.
module greedy_note_dispenser_top import gnd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [VAL_W-1:0] req_note_value,
   input  logic [STK_W-1:0] req_add_count,
   input  logic [VAL_W-1:0] req_amount,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [VAL_W-1:0] rsp_paid_value,
   output logic [STK_W-1:0] rsp_notes_used,
   output logic [VAL_W-1:0] rsp_remainder,
   output logic             rsp_last
);
   cmd_type cmd;
   sts_type sts;
   logic [VAL_W-1:0] best_value, rem_value;
   logic [STK_W-1:0] use_count;

   gnd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_note_value,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_paid_value, .rsp_notes_used,
      .rsp_remainder, .rsp_last, .cmd, .sts, .best_value, .use_count,
      .rem_value
   );

   gnd_datapath u_dp (
      .clock, .reset, .cmd, .req_note_value, .req_add_count, .req_amount,
      .sts, .best_value, .use_count, .rem_value
   );
endmodule

// ----- rtl/gnd_datapath.sv -----
// Slot table, best-slot search and bit-serial divider.
module gnd_datapath import gnd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  logic [VAL_W-1:0] req_note_value,
   input  logic [STK_W-1:0] req_add_count,
   input  logic [VAL_W-1:0] req_amount,
   output sts_type          sts,
   output logic [VAL_W-1:0] best_value,
   output logic [STK_W-1:0] use_count,
   output logic [VAL_W-1:0] rem_value
);
   logic [VAL_W-1:0] slot_value_ff [SLOTS];
   logic [STK_W-1:0] slot_stock_ff [SLOTS];
   logic [SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [SLOTS-1:0] seen_ff;
   logic [VAL_W-1:0] val_ff, rem_ff, rem_in;
   logic [STK_W-1:0] cnt_ff;
   logic [SLOT_W-1:0] best_ff;
   logic [VAL_W-1:0] quo_ff, part_ff, dvd_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;

   logic [SLOT_W-1:0] match_idx, free_idx, best_idx;
   logic found, has_free, best_ok;
   logic [VAL_W:0] trial;
   logic [STK_W:0] sum;
   logic [STK_W-1:0] use_c, stk;
   logic [VAL_W-1:0] bval;
   logic [VAL_W+STK_W-1:0] prod;

   always_comb begin
      found = 1'b0; match_idx = '0; has_free = 1'b0; free_idx = '0;
      best_ok = 1'b0; best_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_valid_ff[i] && slot_value_ff[i] == val_ff) begin
            found = 1'b1; match_idx = SLOT_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            has_free = 1'b1; free_idx = SLOT_W'(i);
         end
      end
      // Ascending scan with strict compare keeps lowest index on ties.
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid_ff[i] && !seen_ff[i] &&
             (!best_ok || slot_value_ff[i] > slot_value_ff[best_idx])) begin
            best_ok = 1'b1; best_idx = SLOT_W'(i);
         end
      end
   end

   assign bval  = slot_value_ff[best_ff];
   assign stk   = slot_stock_ff[best_ff];
   assign trial = {part_ff, dvd_ff[VAL_W-1]} - {1'b0, bval};
   assign use_c = (quo_ff > VAL_W'(stk)) ? stk : quo_ff[STK_W-1:0];
   assign prod  = use_c * bval;
   assign rem_in = rem_ff - prod[VAL_W-1:0];
   assign sum   = {1'b0, slot_stock_ff[match_idx]} + {1'b0, cnt_ff};

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (cmd.do_add && val_ff != '0 && !found && has_free)
         slot_valid_in[free_idx] = 1'b1;
      if (cmd.do_remove && found) slot_valid_in[match_idx] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         seen_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         if (cmd.load) seen_ff <= '0;
         if (cmd.pick && best_ok) seen_ff[best_idx] <= 1'b1;
         if (cmd.div_start) dcnt_ff <= DIV_CNT_W'(VAL_W);
         else if (cmd.div_step && dcnt_ff != '0) dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff <= req_note_value; cnt_ff <= req_add_count; rem_ff <= req_amount;
      end
      if (cmd.pick) best_ff <= best_idx;
      if (cmd.do_add && val_ff != '0) begin
         if (found)
            slot_stock_ff[match_idx] <= sum[STK_W] ? '1 : sum[STK_W-1:0];
         else if (has_free) begin
            slot_value_ff[free_idx] <= val_ff;
            slot_stock_ff[free_idx] <= cnt_ff;
         end
      end
      if (cmd.div_start) begin
         dvd_ff <= rem_ff; part_ff <= '0; quo_ff <= '0;
      end else if (cmd.div_step && dcnt_ff != '0) begin
         dvd_ff <= {dvd_ff[VAL_W-2:0], 1'b0};
         if (!trial[VAL_W]) begin
            part_ff <= trial[VAL_W-1:0]; quo_ff <= {quo_ff[VAL_W-2:0], 1'b1};
         end else begin
            part_ff <= {part_ff[VAL_W-2:0], dvd_ff[VAL_W-1]};
            quo_ff <= {quo_ff[VAL_W-2:0], 1'b0};
         end
      end
      if (cmd.apply) begin
         slot_stock_ff[best_ff] <= stk - use_c;
         rem_ff <= rem_in;
      end
   end

   assign sts.found    = found;
   assign sts.has_free = has_free;
   assign sts.best_ok  = best_ok;
   assign sts.div_done = (dcnt_ff == '0);
   assign sts.use_nz   = (use_c != '0);
   assign sts.rem_nz   = (rem_ff != '0);
   assign best_value = bval;
   assign use_count  = use_c;
   // Show the post-deduction remainder while applying, the settled one otherwise.
   assign rem_value  = cmd.apply ? rem_in : rem_ff;
endmodule

// ----- rtl/gnd_ctrl.sv -----
// Request sequencer and result register.
module gnd_ctrl import gnd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [VAL_W-1:0] req_note_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [VAL_W-1:0] rsp_paid_value,
   output logic [STK_W-1:0] rsp_notes_used,
   output logic [VAL_W-1:0] rsp_remainder,
   output logic             rsp_last,
   output cmd_type          cmd,
   input  sts_type          sts,
   input  logic [VAL_W-1:0] best_value,
   input  logic [STK_W-1:0] use_count,
   input  logic [VAL_W-1:0] rem_value
);
   typedef enum logic [2:0] {
      S_IDLE, S_ADD, S_REMOVE, S_PICK, S_DIV, S_APPLY, S_FINAL, S_WAIT
   } state_type;

   state_type state_ff;
   logic [1:0] type_ff;
   logic zero_ff;
   logic out_free;
   logic rsp_load;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_load  = out_free && (state_ff == S_ADD || state_ff == S_REMOVE ||
                                   state_ff == S_FINAL ||
                                   (state_ff == S_APPLY && sts.use_nz));

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:   cmd.load = req_valid;
         S_ADD:    cmd.do_add = out_free;
         S_REMOVE: cmd.do_remove = out_free;
         S_PICK:   begin cmd.pick = 1'b1; cmd.div_start = sts.best_ok; end
         S_DIV:    cmd.div_step = 1'b1;
         S_APPLY:  cmd.apply = out_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               type_ff <= req_type;
               zero_ff <= (req_note_value == '0);
               unique case (req_type)
                  REQ_ADD:      state_ff <= S_ADD;
                  REQ_REMOVE:   state_ff <= S_REMOVE;
                  REQ_DISPENSE: state_ff <= S_PICK;
                  default:      state_ff <= S_FINAL;
               endcase
            end
            S_ADD: if (out_free) begin
               rsp_last <= 1'b1;
               rsp_paid_value <= '0; rsp_notes_used <= '0; rsp_remainder <= '0;
               rsp_status <= zero_ff ? ST_BAD_VALUE : sts.found ? ST_OK :
                             sts.has_free ? ST_OK : ST_TABLE_FULL;
               state_ff <= S_IDLE;
            end
            S_REMOVE: if (out_free) begin
               rsp_last <= 1'b1;
               rsp_paid_value <= '0; rsp_notes_used <= '0; rsp_remainder <= '0;
               rsp_status <= sts.found ? ST_OK : ST_NOT_FOUND;
               state_ff <= S_IDLE;
            end
            S_PICK: state_ff <= sts.best_ok ? S_DIV : S_FINAL;
            S_DIV:  if (sts.div_done) state_ff <= S_APPLY;
            S_APPLY: if (out_free) begin
               if (sts.use_nz) begin
                  rsp_last <= 1'b0; rsp_status <= ST_OK;
                  rsp_paid_value <= best_value; rsp_notes_used <= use_count;
                  rsp_remainder <= rem_value;
               end
               state_ff <= S_PICK;
            end
            S_FINAL: if (out_free) begin
               rsp_last <= 1'b1;
               rsp_paid_value <= '0; rsp_notes_used <= '0;
               if (type_ff == REQ_DISPENSE) begin
                  rsp_status <= sts.rem_nz ? ST_SHORTFALL : ST_OK;
                  rsp_remainder <= rem_value;
               end else begin
                  rsp_status <= ST_BAD_VALUE; rsp_remainder <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
